FILE: hw/rtl/i2dt_pkg.sv
// Shared constants, types and state encoding for the int64 decimal text unit.
// No dependencies; every other file imports this package.
package i2dt_pkg;

	localparam int NUM_W      = 64;
	localparam int MAX_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int BIT_CNT_W  = $clog2(NUM_W);
	localparam int CAP_W      = 10;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(342);
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// Result of the binary to BCD conversion, handed to the emitter
	typedef struct packed {
		logic             done;
		logic             negative;
		logic [BCD_W-1:0] bcd;
	} bcd_res_t;

	// Emitter sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIP,
		ST_CHECK,
		ST_ERROR,
		ST_SIGN,
		ST_DIGIT
	} emit_st_t;

endpackage

FILE: hw/rtl/i2dt_ifs.sv
// Valid/ready channel interfaces: number input, text output, capacity write.
// Depends on i2dt_pkg for field widths.
interface i2dt_num_if import i2dt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number_value;

	modport source (output valid, output number_value, input ready);
	modport sink (input valid, input number_value, output ready);
endinterface

interface i2dt_txt_if import i2dt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;
	logic              capacity_error;
	logic [LEN_W-1:0]  text_length;

	modport source (output valid, output char_code, output last_char,
		output capacity_error, output text_length, input ready);
	modport sink (input valid, input char_code, input last_char,
		input capacity_error, input text_length, output ready);
endinterface

interface i2dt_cfg_if import i2dt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] buffer_capacity;

	modport source (output valid, output buffer_capacity, input ready);
	modport sink (input valid, input buffer_capacity, output ready);
endinterface

FILE: hw/rtl/int64_to_decimal_text_unit.sv
// Top level of the int64 decimal text unit: capacity register, sign and
// magnitude, BCD converter and text emitter. Depends on i2dt_pkg, i2dt_ifs,
// i2dt_dabble and i2dt_emit.
//
// Usage:
//  num  : one signed 64-bit number_value per transaction.
//  txt  : the decimal text, most significant character first, one
//         character per transaction; a minus sign leads a negative value.
//         last_char marks the final character, which carries text_length.
//         If the length is not below buffer_capacity, a single transaction
//         with capacity_error set replaces the text.
//  cfg  : writes buffer_capacity (reset value 342); write only while idle.
// Timing: one number at a time. After acceptance the converter shifts one
//  magnitude bit per cycle, the emitter drops leading zero digits one per
//  cycle (up to 19), checks the length, then sends one character per cycle
//  while the receiver does not stall.
// Reset clears the channel state and restores the capacity register.
// When the receiver stalls, the output register holds its transaction and
//  the emitter waits; a new number is taken once the last character has
//  been loaded into the output register.
module int64_to_decimal_text_unit import i2dt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	i2dt_num_if.sink   num,
	i2dt_txt_if.source txt,
	i2dt_cfg_if.sink   cfg
);

	logic [CAP_W-1:0] cap_q;
	logic             dab_busy;
	logic             emit_idle;
	bcd_res_t         res;
	logic             start;
	logic             negative;
	logic [NUM_W-1:0] magnitude;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= CAP_RESET;
		else if (cfg.valid && cfg.ready)
			cap_q <= cfg.buffer_capacity;
	end
	assign cfg.ready = 1'b1;

	// sign and unsigned magnitude; 2^63 falls out naturally
	assign negative  = num.number_value[NUM_W-1];
	assign magnitude = negative ? (~num.number_value + NUM_W'(1)) : num.number_value;

	assign num.ready = !dab_busy && !res.done && emit_idle;
	assign start     = num.valid && num.ready;

	i2dt_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.negative  (negative),
		.magnitude (magnitude),
		.busy      (dab_busy),
		.res       (res)
	);

	i2dt_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.capacity (cap_q),
		.idle     (emit_idle),
		.txt      (txt)
	);

endmodule

FILE: hw/rtl/i2dt_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on i2dt_pkg.
module i2dt_dabble import i2dt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             negative,
	input  logic [NUM_W-1:0] magnitude,
	output logic             busy,
	output bcd_res_t         res
);

	logic [NUM_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [BCD_W-1:0]     bcd_adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
				bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			else
				bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W];
		end
	end

	// control: bit counter, busy and one-cycle done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + BIT_CNT_W'(1);
				if (cnt_q == BIT_CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: binary shifts out its msb into the BCD register
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= magnitude;
			bcd_q <= '0;
			neg_q <= negative;
		end else if (busy_q) begin
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUM_W-1]};
		end
	end

	assign busy         = busy_q;
	assign res.done     = done_q;
	assign res.negative = neg_q;
	assign res.bcd      = bcd_q;

endmodule

FILE: hw/rtl/i2dt_emit.sv
// Text emitter: strips leading zero digits, checks capacity, then sends sign
// and digits one per transaction or a lone error. Depends on i2dt_pkg, i2dt_ifs.
module i2dt_emit import i2dt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  bcd_res_t         res,
	input  logic [CAP_W-1:0] capacity,
	output logic             idle,
	i2dt_txt_if.source       txt
);

	emit_st_t          state_q, state_d;
	logic [BCD_W-1:0]  bcd_q;
	logic              neg_q;
	logic [LEN_W-1:0]  ndig_q;
	logic [LEN_W-1:0]  len_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              err_q;
	logic [LEN_W-1:0]  tlen_q;

	logic [DIGIT_W-1:0] top_digit;
	logic               top_zero;
	logic               more_digits;
	logic [LEN_W-1:0]   len_w;
	logic               too_long;
	logic               out_free;
	logic               emit;
	logic               strip_shift;
	logic [CHAR_W-1:0]  char_d;
	logic               last_d;
	logic               err_d;
	logic [LEN_W-1:0]   tlen_d;

	assign top_digit   = bcd_q[BCD_W-1 -: DIGIT_W];
	assign top_zero    = (top_digit == '0);
	assign more_digits = (ndig_q != LEN_W'(1));
	assign len_w       = ndig_q + LEN_W'(neg_q);
	assign too_long    = ({{(CAP_W-LEN_W){1'b0}}, len_w} >= capacity);
	assign out_free    = !valid_q || txt.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (res.done) state_d = ST_STRIP;
			ST_STRIP: if (!(top_zero && more_digits)) state_d = ST_CHECK;
			ST_CHECK: begin
				if (too_long)   state_d = ST_ERROR;
				else if (neg_q) state_d = ST_SIGN;
				else            state_d = ST_DIGIT;
			end
			ST_ERROR: if (out_free) state_d = ST_IDLE;
			ST_SIGN:  if (out_free) state_d = ST_DIGIT;
			ST_DIGIT: if (out_free && !more_digits) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: shift enables and the next result
	always_comb begin
		strip_shift = 1'b0;
		emit        = 1'b0;
		char_d      = '0;
		last_d      = 1'b0;
		err_d       = 1'b0;
		tlen_d      = '0;
		unique case (state_q)
			ST_STRIP: strip_shift = top_zero && more_digits;
			ST_ERROR: begin
				emit   = out_free;
				last_d = 1'b1;
				err_d  = 1'b1;
			end
			ST_SIGN: begin
				emit   = out_free;
				char_d = CHAR_MINUS;
				last_d = (len_q == LEN_W'(1));
				tlen_d = last_d ? len_q : '0;
			end
			ST_DIGIT: begin
				emit   = out_free;
				char_d = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
				last_d = !more_digits;
				tlen_d = last_d ? len_q : '0;
			end
			default: ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				valid_q <= 1'b1;
			else if (txt.ready)
				valid_q <= 1'b0;
		end
	end

	// digit register, counts and result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && res.done) begin
			bcd_q  <= res.bcd;
			neg_q  <= res.negative;
			ndig_q <= LEN_W'(MAX_DIGITS);
		end else if (strip_shift || (emit && state_q == ST_DIGIT)) begin
			bcd_q  <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			ndig_q <= ndig_q - LEN_W'(1);
		end
		if (state_q == ST_CHECK)
			len_q <= len_w;
		if (emit) begin
			char_q <= char_d;
			last_q <= last_d;
			err_q  <= err_d;
			tlen_q <= tlen_d;
		end
	end

	assign idle               = (state_q == ST_IDLE);
	assign txt.valid          = valid_q;
	assign txt.char_code      = char_q;
	assign txt.last_char      = last_q;
	assign txt.capacity_error = err_q;
	assign txt.text_length    = tlen_q;

endmodule

FILE: hw/rtl/i2dt_chk.sv
// Port-level checker for int64_to_decimal_text_unit, bound to the top level.
// Depends on i2dt_pkg.
module i2dt_chk import i2dt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              num_ready,
	input logic              txt_valid,
	input logic              txt_ready,
	input logic [CHAR_W-1:0] char_code,
	input logic              last_char,
	input logic              capacity_error,
	input logic [LEN_W-1:0]  text_length
);

	// an error transaction is a lone, empty final result
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && capacity_error |->
		last_char && char_code == '0 && text_length == '0)
		else $error("capacity error result malformed");

	// characters before the last carry no length and no error
	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !last_char |-> text_length == '0 && !capacity_error)
		else $error("non-final character carries length or error");

	// a good final character reports a length of 1 to 20
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && last_char && !capacity_error |->
		text_length != '0 && text_length <= LEN_W'(MAX_DIGITS))
		else $error("text length out of range");

	// no new number while a text run is still being sent
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !last_char |-> !num_ready)
		else $error("input accepted during a text run");

	// a stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		txt_valid && !txt_ready |=> txt_valid && $stable(char_code) &&
		$stable(last_char) && $stable(text_length))
		else $error("stalled output changed");

endmodule

bind int64_to_decimal_text_unit i2dt_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.num_ready      (num.ready),
	.txt_valid      (txt.valid),
	.txt_ready      (txt.ready),
	.char_code      (txt.char_code),
	.last_char      (txt.last_char),
	.capacity_error (txt.capacity_error),
	.text_length    (txt.text_length)
);
